@@ src/wpw_pkg.sv @@
// ----------------------------------------------------------------------------
// wpw_pkg - shared constants for the wavetable phase warp
// Mode codes, register map, pipeline step counts and the exp2 root table.
// ----------------------------------------------------------------------------
package wpw_pkg;

  localparam int PFB_DEFAULT = 24;
  localparam int MQS_DEFAULT = 256;

  // warp modes
  localparam logic [3:0] MODE_NONE  = 4'd0;
  localparam logic [3:0] MODE_SYNC  = 4'd1;
  localparam logic [3:0] MODE_BUP   = 4'd2;
  localparam logic [3:0] MODE_BDN   = 4'd3;
  localparam logic [3:0] MODE_MIRR  = 4'd4;
  localparam logic [3:0] MODE_ASYM  = 4'd5;
  localparam logic [3:0] MODE_QUANT = 4'd6;
  localparam logic [3:0] MODE_FM    = 4'd7;
  localparam logic [3:0] MODE_FLIP  = 4'd8;

  // register index (word address)
  localparam logic REG_WARP_MODE = 1'b0;

  localparam int LOG_STEPS = 24;
  localparam int EXP_STEPS = 24;
  localparam int DIV_QW    = 31;
  localparam int DIV_DW    = 31;
  localparam int MIN_STEPS = 4;

  localparam logic [16:0] Q16_ONE  = 17'd65536;
  localparam logic [14:0] C_POINT3 = 15'd19661;
  localparam logic [15:0] Q16_HALF = 16'd32768;

  // 2^(-2^-idx) in Q1.30: repeated floor square roots starting from 0.5
  function automatic logic [29:0] exp_coef(input int idx);
    logic [63:0] c;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bt;
    int i;
    int j;
    c = 64'd1 << 29;
    for (i = 1; i <= EXP_STEPS; i++) begin
      if (i <= idx) begin
        n   = c << 30;
        res = '0;
        bt  = 64'd1 << 62;
        for (j = 0; j < 32; j++) begin
          if (bt > n) bt = bt >> 2;
        end
        for (j = 0; j < 32; j++) begin
          if (bt != 64'd0) begin
            if (n >= res + bt) begin
              n   = n - (res + bt);
              res = (res >> 1) + bt;
            end else begin
              res = res >> 1;
            end
            bt = bt >> 2;
          end
        end
        c = res;
      end
    end
    return c[29:0];
  endfunction

endpackage

@@ src/wavetable_phase_warp.sv @@
// ----------------------------------------------------------------------------
// wavetable_phase_warp - phase distortion stage for a wavetable oscillator
// Wraps and shapes an oscillator phase by the mode held in warp_mode.
// ----------------------------------------------------------------------------
// A phase beat is taken on every clock where start is high (busy stays low).
// Its warped phase appears on warped_phase, flagged by a one-cycle done
// strobe, and beats come out in the order they went in. One beat per clock
// is sustained indefinitely. The receiver cannot stall the pipeline, so it
// must take each result in the cycle done is high. The latency is set by
// the bit-serial units laid out as pipeline stages: 24 squaring stages for
// log2, 31 restoring-divide stages shared by bend down, mirror and quantize,
// and 24 multiply stages for exp2, plus input, three preparation stages, a
// scaling stage and the output register. warp_mode is captured with each
// beat at input; write it only while the pipe is empty.
// ----------------------------------------------------------------------------
module wavetable_phase_warp import wpw_pkg::*; #(
  parameter int PHASE_FRAC_BITS = PFB_DEFAULT,
  parameter int MAX_QUANT_STEPS = MQS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] phase_in,
  input  logic [16:0]        warp_amount,
  input  logic signed [15:0] prev_sample,
  // result channel
  output logic               done,
  output logic signed [31:0] warped_phase,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int F    = PHASE_FRAC_BITS;
  localparam int MQ   = MAX_QUANT_STEPS;
  localparam int SW   = $clog2(MQ + 1);
  localparam int DECW = 17 + SW + 1;
  localparam int DDW  = DIV_QW + DIV_DW;
  localparam logic [63:0] ONE_V = 64'd1 << F;

  // everything one beat carries down the pipe
  typedef struct packed {
    logic [31:0]        pin;
    logic [F-1:0]       p;
    logic [3:0]         mode;
    logic               byp;
    logic [16:0]        a;
    logic signed [15:0] s;
    logic [14:0]        c3;
    logic [SW-1:0]      dec;
    logic [18:0]        e16;
    logic [31:0]        r;      // result for the single-stage modes
    logic [SW-1:0]      steps;
    logic [F-1:0]       mid;
    logic               gt;
    logic [30:0]        m;      // Q1.30 mantissa for log2
    logic [4:0]         lz;
    logic [23:0]        frac;
    logic [30:0]        n;      // exponent, Q.24
    logic [DIV_DW-1:0]  rem;
    logic [DIV_QW-1:0]  lo;     // dividend low bits, then quotient
    logic [DIV_DW-1:0]  dvs;
    logic [30:0]        v;      // Q1.30 exp2 accumulator
  } pipe_t;

  // ---------------------------------------------------------------------------
  // stage functions
  // ---------------------------------------------------------------------------

  // wrap, simple modes, normalise for log2
  function automatic pipe_t f_prep1(input pipe_t x);
    logic [31:0]        c3p;
    logic [DECW-1:0]    decp;
    logic [F+19:0]      sp;
    logic [F+17:0]      f1;
    logic [F+17:0]      f2;
    logic [F+17:0]      fs;
    logic signed [33:0] sa;
    logic signed [33:0] off;
    logic [F-1:0]       fmr;
    int                 msb;
    int                 i;
    pipe_t              y;
    y      = x;
    y.p    = x.pin[F-1:0];
    y.byp  = (x.a == 17'd0) || (x.mode == MODE_NONE);
    c3p    = 32'(x.a) * 32'(C_POINT3);
    y.c3   = 15'(c3p >> 16);
    decp   = DECW'(x.a) * DECW'(MQ - 4) + DECW'(65535);
    y.dec  = SW'(decp >> 16);
    y.e16  = 19'(Q16_ONE) + 19'(x.a) + 19'({x.a, 1'b0});
    // sync: p * (1 + 7a)
    sp     = (F+20)'(y.p) * (F+20)'(20'({x.a, 3'b000}) - 20'(x.a) + 20'(Q16_ONE));
    // flip: cross-fade of the upper half
    f1     = (F+18)'(y.p) * (F+18)'(Q16_ONE - x.a);
    f2     = ((F+18)'(ONE_V) - (F+18)'(y.p)) * (F+18)'(x.a);
    fs     = f1 + f2;
    // fm: offset rounded toward minus infinity
    sa     = 34'(x.s) * 34'(signed'({1'b0, x.a}));
    off    = sa >>> (32 - F);
    fmr    = y.p + off[F-1:0];
    y.r    = 32'(y.p);
    case (x.mode)
      MODE_SYNC: y.r = 32'(sp[F+15:16]);
      MODE_FM:   y.r = 32'(fmr);
      MODE_FLIP: y.r = y.p[F-1] ? 32'(fs >> 16) : 32'(y.p);
      default:   ;
    endcase
    msb = 0;
    for (i = 0; i < F; i++) begin
      if (y.p[i]) msb = i;
    end
    y.lz = 5'(F - 1 - msb);
    y.m  = 31'({y.p, {(31-F){1'b0}}} << y.lz);
    return y;
  endfunction

  // quantize step count, mirror mid point, asym
  function automatic pipe_t f_prep2(input pipe_t x);
    logic [SW-1:0]  stp;
    logic [15:0]    m16;
    logic [15:0]    s16;
    logic [F-1:0]   st;
    logic           lt;
    logic [F-1:0]   ax;
    logic [F:0]     ay;
    logic [2*F:0]   ap;
    logic [2*F:0]   at;
    pipe_t          y;
    y   = x;
    stp = (SW'(MQ) > x.dec) ? SW'(MQ) - x.dec : '0;
    if (stp < SW'(MIN_STEPS)) stp = SW'(MIN_STEPS);
    y.steps = stp;
    m16   = Q16_HALF - 16'(x.c3);
    s16   = Q16_HALF + 16'(x.c3);
    y.mid = F'(((F+16)'(m16) << F) >> 16);
    st    = F'(((F+16)'(s16) << F) >> 16);
    y.gt  = x.p > y.mid;
    lt    = !x.p[F-1];
    ax    = lt ? x.p : {1'b0, x.p[F-2:0]};
    ay    = lt ? (F+1)'(st) : (F+1)'(ONE_V) - (F+1)'(st);
    ap    = (2*F+1)'(ax) * (2*F+1)'(ay);
    at    = ap >> (F - 1);
    if (x.mode == MODE_ASYM) y.r = 32'((lt ? (2*F+1)'(0) : (2*F+1)'(st)) + at);
    if ((x.mode == MODE_MIRR) && y.gt) y.r = 32'({y.mid, 1'b0}) - 32'(x.p);
    return y;
  endfunction

  // divider operands for mirror and quantize
  function automatic pipe_t f_prep3(input pipe_t x);
    logic [F+SW-1:0] qp;
    logic [SW-1:0]   q;
    logic [DDW-1:0]  dvd;
    pipe_t           y;
    y   = x;
    qp  = (F+SW)'(x.p) * (F+SW)'(x.steps);
    q   = qp[F+SW-1:F];
    dvd = (x.mode == MODE_MIRR) ? DDW'(x.p) << (F - 1) : DDW'(q) << F;
    y.rem = dvd[DDW-1:DIV_QW];
    y.lo  = dvd[DIV_QW-1:0];
    y.dvs = (x.mode == MODE_MIRR) ? DIV_DW'(x.mid) : DIV_DW'(x.steps);
    return y;
  endfunction

  // one squaring step of log2
  function automatic pipe_t f_log(input pipe_t x);
    logic [61:0] sq;
    logic [31:0] m2;
    pipe_t       y;
    y      = x;
    sq     = 62'(x.m) * 62'(x.m);
    m2     = sq[61:30];
    y.m    = m2[31] ? m2[31:1] : m2[30:0];
    y.frac = {x.frac[22:0], m2[31]};
    return y;
  endfunction

  // scale |log2| by the bend exponent; for bend down, set up the divide by it
  function automatic pipe_t f_scale(input pipe_t x);
    logic [29:0]    mag;
    logic [48:0]    np;
    logic [DDW-1:0] dvd;
    pipe_t          y;
    y   = x;
    mag = {1'b0, 5'(x.lz + 5'd1), 24'd0} - 30'(x.frac);
    np  = 49'(mag) * 49'(x.e16);
    y.n = 31'(np >> 16);
    if (x.mode == MODE_BDN) begin
      dvd   = DDW'(mag) << 16;
      y.rem = dvd[DDW-1:DIV_QW];
      y.lo  = dvd[DIV_QW-1:0];
      y.dvs = DIV_DW'(x.e16);
    end
    return y;
  endfunction

  // one restoring divide step
  function automatic pipe_t f_div(input pipe_t x);
    logic [DIV_DW:0] t;
    logic            ge;
    pipe_t           y;
    y     = x;
    t     = {x.rem, x.lo[DIV_QW-1]};
    ge    = t >= {1'b0, x.dvs};
    y.rem = ge ? DIV_DW'(t - {1'b0, x.dvs}) : DIV_DW'(t);
    y.lo  = {x.lo[DIV_QW-2:0], ge};
    return y;
  endfunction

  // one exp2 factor; bit sel of the exponent fraction
  function automatic pipe_t f_exp(input pipe_t x, input logic [29:0] coef,
                                  input int sel);
    logic [60:0] pr;
    pipe_t       y;
    y  = x;
    pr = 61'(x.v) * 61'(coef);
    if (x.n[sel]) y.v = 31'(pr >> 30);
    return y;
  endfunction

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  logic [3:0] warp_mode;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = (paddr[2] == REG_WARP_MODE) ? {28'd0, warp_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      warp_mode <= MODE_NONE;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WARP_MODE)) begin
      warp_mode <= pwdata[3:0];
    end
  end

  // ---------------------------------------------------------------------------
  // input and preparation stages
  // ---------------------------------------------------------------------------
  pipe_t s0, s1, s2, s3, s4;
  logic  v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // incoming beat, depth saturated
  always_comb begin
    s0      = '0;
    s0.pin  = phase_in;
    s0.a    = (warp_amount > Q16_ONE) ? Q16_ONE : warp_amount;
    s0.s    = prev_sample;
    s0.mode = warp_mode;
    s0.v    = 31'd1 << 30;
  end

  always_ff @(posedge clk) begin
    s1 <= s0;
    s2 <= f_prep1(s1);
    s3 <= f_prep2(s2);
    s4 <= f_prep3(s3);
  end

  // ---------------------------------------------------------------------------
  // log2: one squaring per stage
  // ---------------------------------------------------------------------------
  pipe_t                lc  [LOG_STEPS+1];
  logic [LOG_STEPS:0]   lvc;

  assign lc[0]  = s4;
  assign lvc[0] = v4;

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
    always_ff @(posedge clk) begin
      if (rst) lvc[i+1] <= 1'b0;
      else     lvc[i+1] <= lvc[i];
    end
    always_ff @(posedge clk) begin
      lc[i+1] <= f_log(lc[i]);
    end
  end

  // scaling by the bend exponent
  pipe_t sc;
  logic  scv;

  always_ff @(posedge clk) begin
    if (rst) scv <= 1'b0;
    else     scv <= lvc[LOG_STEPS];
  end

  always_ff @(posedge clk) begin
    sc <= f_scale(lc[LOG_STEPS]);
  end

  // ---------------------------------------------------------------------------
  // shared divider: one quotient bit per stage
  // ---------------------------------------------------------------------------
  pipe_t             dc  [DIV_QW+1];
  logic [DIV_QW:0]   dvc;

  assign dc[0]  = sc;
  assign dvc[0] = scv;

  for (genvar i = 0; i < DIV_QW; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dvc[i+1] <= 1'b0;
      else     dvc[i+1] <= dvc[i];
    end
    always_ff @(posedge clk) begin
      dc[i+1] <= f_div(dc[i]);
    end
  end

  // bend down takes its exponent from the quotient
  pipe_t ex_in;

  always_comb begin
    ex_in = dc[DIV_QW];
    if (ex_in.mode == MODE_BDN) ex_in.n = 31'(dc[DIV_QW].lo);
  end

  // ---------------------------------------------------------------------------
  // exp2: one root factor per stage, fraction bits msb first
  // ---------------------------------------------------------------------------
  pipe_t               ec  [EXP_STEPS+1];
  logic [EXP_STEPS:0]  evc;

  assign ec[0]  = ex_in;
  assign evc[0] = dvc[DIV_QW];

  for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
    localparam logic [29:0] COEF = exp_coef(i + 1);
    always_ff @(posedge clk) begin
      if (rst) evc[i+1] <= 1'b0;
      else     evc[i+1] <= evc[i];
    end
    always_ff @(posedge clk) begin
      ec[i+1] <= f_exp(ec[i], COEF, EXP_STEPS - 1 - i);
    end
  end

  // ---------------------------------------------------------------------------
  // final select and output register
  // ---------------------------------------------------------------------------
  pipe_t       fin;
  logic [6:0]  ek;
  logic [7:0]  esh;
  logic [30:0] ev;
  logic [31:0] result;

  always_comb begin
    fin = ec[EXP_STEPS];
    ek  = fin.n[30:24];
    esh = 8'(30 - F) + 8'(ek);
    ev  = (esh >= 8'd40) ? 31'd0 : 31'(fin.v >> esh);
    result = fin.r;
    case (fin.mode)
      MODE_BUP, MODE_BDN: result = (fin.p == '0) ? 32'd0 : 32'(ev);
      MODE_MIRR:          result = fin.gt ? fin.r : 32'(fin.lo);
      MODE_QUANT:         result = 32'(fin.lo);
      default:            ;
    endcase
    if (fin.byp) result = fin.pin;  // zero depth or no mode: unwrapped pass
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= evc[EXP_STEPS];
  end

  always_ff @(posedge clk) begin
    warped_phase <= result;
  end

endmodule
